### rtl/cdq_pkg.sv
// Shared types and constants for the circular double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CAP_W = 7;
  localparam int unsigned DATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

### rtl/cdq_ctrl.sv
// Request sequencer: accepts one request, then holds its response until taken.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output cdq_pkg::ctrl_cmd_t    cmd_o
);

  cdq_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.exec  = 1'b0;
    unique case (state_q)
      cdq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = cdq_pkg::S_RESP;
        end
      end
      cdq_pkg::S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = cdq_pkg::S_IDLE;
        end
      end
      default: state_d = cdq_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/cdq_datapath.sv
// Queue pointers, slot store and response registers.
`timescale 1ns / 1ps
`default_nettype none

module cdq_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cdq_pkg::ctrl_cmd_t            cmd_i,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [cdq_pkg::DATA_W-1:0]    push_value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [cdq_pkg::CAP_W-1:0]     cfg_data_i,
  output logic      [1:0]                    status_o,
  output logic      [cdq_pkg::DATA_W-1:0]    popped_value_o
);

  logic [cdq_pkg::DATA_W-1:0] mem [cdq_pkg::DEPTH];

  logic [cdq_pkg::IDX_W-1:0] head_q, head_d;
  logic [cdq_pkg::IDX_W-1:0] tail_q, tail_d;
  logic                      empty_q, empty_d;
  logic [cdq_pkg::CAP_W-1:0] cap_q;
  cdq_pkg::status_e          status_q, status_d;
  logic                      pop_ok_q, pop_ok_d;
  logic [cdq_pkg::DATA_W-1:0] rd_data_q;

  logic [cdq_pkg::IDX_W-1:0] last;
  logic                      full;
  logic                      mem_we;
  logic [cdq_pkg::IDX_W-1:0] mem_waddr;
  logic [cdq_pkg::IDX_W-1:0] mem_raddr;
  cdq_pkg::op_e              op;

  assign op = cdq_pkg::op_e'(operation_i);

  // Capacity in force: zero acts as one, values above the store depth clamp.
  always_comb begin
    priority if (cap_q == '0) begin
      last = '0;
    end else if (cap_q > cdq_pkg::CAP_W'(cdq_pkg::DEPTH)) begin
      last = cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);
    end else begin
      last = cdq_pkg::IDX_W'(cap_q - cdq_pkg::CAP_W'(1));
    end
  end

  assign full = (head_q == '0 && tail_q == last) ||
                ({1'b0, head_q} == ({1'b0, tail_q} + (cdq_pkg::IDX_W + 1)'(1)));

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    status_d  = status_q;
    pop_ok_d  = pop_ok_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_raddr = head_q;
    if (cfg_we_i) begin
      head_d  = '0;
      tail_d  = '0;
      empty_d = 1'b1;
    end else if (cmd_i.exec) begin
      status_d = cdq_pkg::ST_OK;
      pop_ok_d = 1'b0;
      unique case (op)
        cdq_pkg::OP_PUSH_REAR, cdq_pkg::OP_PUSH_FRONT: begin
          if (empty_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b0;
            mem_we  = 1'b1;
          end else if (full) begin
            status_d = cdq_pkg::ST_FULL;
          end else if (op == cdq_pkg::OP_PUSH_REAR) begin
            tail_d    = (tail_q == last) ? '0 : tail_q + cdq_pkg::IDX_W'(1);
            mem_we    = 1'b1;
            mem_waddr = tail_d;
          end else begin
            head_d    = (head_q == '0) ? last : head_q - cdq_pkg::IDX_W'(1);
            mem_we    = 1'b1;
            mem_waddr = head_d;
          end
        end
        cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
          if (empty_q) begin
            status_d = cdq_pkg::ST_EMPTY;
          end else begin
            pop_ok_d = 1'b1;
            if (op == cdq_pkg::OP_POP_REAR) begin
              mem_raddr = tail_q;
            end
            if (head_q == tail_q) begin
              head_d  = '0;
              tail_d  = '0;
              empty_d = 1'b1;
            end else if (op == cdq_pkg::OP_POP_FRONT) begin
              head_d = (head_q == last) ? '0 : head_q + cdq_pkg::IDX_W'(1);
            end else begin
              tail_d = (tail_q == '0) ? last : tail_q - cdq_pkg::IDX_W'(1);
            end
          end
        end
        default: status_d = cdq_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      empty_q  <= 1'b1;
      cap_q    <= cdq_pkg::CAP_RESET;
      status_q <= cdq_pkg::ST_OK;
      pop_ok_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      empty_q  <= empty_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= push_value_i;
    end
    if (cmd_i.exec) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign status_o       = status_q;
  assign popped_value_o = pop_ok_q ? rd_data_q : '0;

endmodule

`default_nettype wire

### rtl/circular_deque_top.sv
// Top level of the circular double-ended queue.
//
// Requests arrive on a valid/ready channel carrying an operation code
// (push rear, push front, pop front, pop rear) and a 32-bit push value.
// Every request produces exactly one response on a second valid/ready
// channel with a status (ok, full, empty) and the popped word, which is
// zero for pushes and refused pops.
// A request is executed in the cycle it is accepted; its response is
// valid in the following cycle. The block handles one request at a time:
// it accepts a request and hands over its response before it accepts
// the next, set by the accept/respond sequencer and the registered read
// port of the slot store.
// While the receiver stalls, the response is held and no new request is
// accepted.
// Reset empties the queue and sets the capacity to 64. Writing the
// capacity register also empties the queue; it takes effect at once.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 operation_i,
  input  wire logic [cdq_pkg::DATA_W-1:0] push_value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [1:0]                 status_o,
  output logic      [cdq_pkg::DATA_W-1:0] popped_value_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [cdq_pkg::CAP_W-1:0]  cfg_data_i
);

  cdq_pkg::ctrl_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  cdq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o)
  );

endmodule

`default_nettype wire
